FILE: rtl/sqr_pkg.sv
package sqr_pkg;

	localparam int unsigned CHAR_W = 21;
	localparam int unsigned LEN_W = 16;

	localparam logic [LEN_W-1:0] LEN_CAP = 16'hFFFF;

	localparam logic [CHAR_W-1:0] CH_BACKSLASH = 21'h00005C;
	localparam logic [CHAR_W-1:0] CH_SQUOTE = 21'h000027;
	localparam logic [CHAR_W-1:0] CH_DQUOTE = 21'h000022;
	localparam logic [CHAR_W-1:0] CH_DOLLAR = 21'h000024;
	localparam logic [CHAR_W-1:0] CH_NEWLINE = 21'h00000A;

	typedef enum logic [1:0] {
		MODE_PLAIN = 2'd0,
		MODE_SINGLE = 2'd1,
		MODE_DOUBLE = 2'd2
	} mode_t;

	typedef struct packed {
		mode_t mode;
		logic esc;
		logic [LEN_W-1:0] count;
	} word_state_t;

	typedef struct packed {
		logic [CHAR_W-1:0] char_val;
		logic is_end;
		logic [LEN_W-1:0] len;
	} result_t;

	typedef struct packed {
		result_t [2:0] res;
		logic [1:0] count;
	} bundle_t;

endpackage

FILE: rtl/sqr_in_if.sv
interface sqr_in_if;
	logic valid;
	logic ready;
	logic [sqr_pkg::CHAR_W-1:0] char_in;
	logic last_char;

	modport source (output valid, output char_in, output last_char, input ready);
	modport sink (input valid, input char_in, input last_char, output ready);
endinterface

FILE: rtl/sqr_out_if.sv
interface sqr_out_if;
	logic valid;
	logic ready;
	logic [sqr_pkg::CHAR_W-1:0] char_out;
	logic is_end;
	logic [sqr_pkg::LEN_W-1:0] out_length;

	modport source (output valid, output char_out, output is_end, output out_length,
		input ready);
	modport sink (input valid, input char_out, input is_end, input out_length,
		output ready);
endinterface

FILE: rtl/shell_quote_remover.sv
// A beat's results pass through the pending stage register and then the output register.
// Throughput: one beat per cycle while each beat yields at most one result and the sink is ready.
// A beat with k results (up to three) holds the input side until its last one moves to the output reg.
// Results leave one per cycle while the sink is ready; the output register lets input go on while one waits.
// Reset clears the quote mode, the pending backslash, the length count and all valid flags.
module shell_quote_remover (
	input logic clk,
	input logic arst_n,
	sqr_in_if.sink chars,
	sqr_out_if.source results
);

	sqr_pkg::word_state_t state_q;
	sqr_pkg::word_state_t nxt_state;
	sqr_pkg::bundle_t bundle;

	logic valid_s1;
	logic [1:0] rem_s1;
	sqr_pkg::result_t [2:0] res_s1;

	logic out_valid_q;
	sqr_pkg::result_t out_q;

	logic accept;
	logic out_load;

	sqr_decode u_decode (
		.cur(state_q),
		.ch(chars.char_in),
		.last(chars.last_char),
		.nxt(nxt_state),
		.bundle(bundle)
	);

	assign out_load = valid_s1 && (!out_valid_q || results.ready);
	assign chars.ready = !valid_s1 || (out_load && rem_s1 == 2'd1);
	assign accept = chars.valid && chars.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode <= sqr_pkg::MODE_PLAIN;
			state_q.esc <= 1'b0;
			state_q.count <= '0;
			valid_s1 <= 1'b0;
			rem_s1 <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				state_q <= nxt_state;
				valid_s1 <= bundle.count != 2'd0;
				rem_s1 <= bundle.count;
			end else if (out_load) begin
				valid_s1 <= rem_s1 != 2'd1;
				rem_s1 <= rem_s1 - 2'd1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= bundle.res;
		end else if (out_load) begin
			res_s1[0] <= res_s1[1];
			res_s1[1] <= res_s1[2];
		end
		if (out_load) begin
			out_q <= res_s1[0];
		end
	end

	assign results.valid = out_valid_q;
	assign results.char_out = out_q.char_val;
	assign results.is_end = out_q.is_end;
	assign results.out_length = out_q.len;

	a_s1_count: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> rem_s1 != 2'd0)
		else $error("pending stage holds no results");

	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> chars.ready)
		else $error("input stalled with nothing pending");

	a_word_reset: assert property (@(posedge clk) disable iff (!arst_n)
		(chars.valid && chars.ready && chars.last_char) |=>
			(state_q.count == '0 && state_q.mode == sqr_pkg::MODE_PLAIN && !state_q.esc))
		else $error("word state not cleared after the last character");

	a_char_len: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && !results.is_end) |-> results.out_length != '0)
		else $error("character result carries zero length");

endmodule

FILE: rtl/sqr_decode.sv
module sqr_decode (
	input sqr_pkg::word_state_t cur,
	input logic [sqr_pkg::CHAR_W-1:0] ch,
	input logic last,
	output sqr_pkg::word_state_t nxt,
	output sqr_pkg::bundle_t bundle
);

	function automatic logic [sqr_pkg::LEN_W-1:0] sat_inc(input logic [sqr_pkg::LEN_W-1:0] v);
		if (v < sqr_pkg::LEN_CAP) begin
			return v + 1'b1;
		end
		return v;
	endfunction

	logic [sqr_pkg::LEN_W-1:0] cnt1;
	logic [sqr_pkg::LEN_W-1:0] cnt2;
	logic [1:0] emit;
	logic [sqr_pkg::CHAR_W-1:0] c0;
	logic special;
	sqr_pkg::word_state_t upd;
	sqr_pkg::result_t end_res;

	always_comb begin
		cnt1 = sat_inc(cur.count);
		cnt2 = sat_inc(cnt1);
		special = ch inside {sqr_pkg::CH_DQUOTE, sqr_pkg::CH_SQUOTE, sqr_pkg::CH_DOLLAR,
			sqr_pkg::CH_NEWLINE};
		upd = cur;
		emit = 2'd0;
		c0 = ch;
		case (cur.mode)
			sqr_pkg::MODE_SINGLE: begin
				if (ch == sqr_pkg::CH_SQUOTE) begin
					upd.mode = sqr_pkg::MODE_PLAIN;
				end else begin
					emit = 2'd1;
				end
			end
			sqr_pkg::MODE_DOUBLE: begin
				if (cur.esc) begin
					upd.esc = 1'b0;
					if (special) begin
						emit = 2'd1;
					end else begin
						emit = 2'd2;
						c0 = sqr_pkg::CH_BACKSLASH;
					end
				end else if (ch == sqr_pkg::CH_BACKSLASH) begin
					upd.esc = 1'b1;
				end else if (ch == sqr_pkg::CH_DQUOTE) begin
					upd.mode = sqr_pkg::MODE_PLAIN;
				end else begin
					emit = 2'd1;
				end
			end
			default: begin
				upd.mode = sqr_pkg::MODE_PLAIN;
				if (cur.esc) begin
					upd.esc = 1'b0;
					emit = 2'd1;
				end else if (ch == sqr_pkg::CH_BACKSLASH) begin
					upd.esc = 1'b1;
				end else if (ch == sqr_pkg::CH_SQUOTE) begin
					upd.mode = sqr_pkg::MODE_SINGLE;
				end else if (ch == sqr_pkg::CH_DQUOTE) begin
					upd.mode = sqr_pkg::MODE_DOUBLE;
				end else begin
					emit = 2'd1;
				end
			end
		endcase

		case (emit)
			2'd0: upd.count = cur.count;
			2'd1: upd.count = cnt1;
			default: upd.count = cnt2;
		endcase

		end_res.char_val = '0;
		end_res.is_end = 1'b1;
		end_res.len = upd.count;

		bundle.res[0].char_val = c0;
		bundle.res[0].is_end = 1'b0;
		bundle.res[0].len = cnt1;
		bundle.res[1].char_val = ch;
		bundle.res[1].is_end = 1'b0;
		bundle.res[1].len = cnt2;
		bundle.res[2] = end_res;
		bundle.count = emit + {1'b0, last};

		nxt = upd;
		if (last) begin
			bundle.res[emit] = end_res;
			nxt.mode = sqr_pkg::MODE_PLAIN;
			nxt.esc = 1'b0;
			nxt.count = '0;
		end
	end

endmodule

FILE: dv/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [sqr_pkg::CHAR_W-1:0] ch;
		logic last;
		int typed_n;
		sqr_pkg::result_t r0;
		sqr_pkg::result_t r1;
		sqr_pkg::result_t r2;
	} stim_row_t;

	logic clk;
	logic arst_n;

	sqr_in_if chars_if();
	sqr_out_if res_if();

	shell_quote_remover dut (
		.clk(clk),
		.arst_n(arst_n),
		.chars(chars_if),
		.results(res_if)
	);

	sqr_pkg::word_state_t word_st;
	sqr_pkg::result_t dequoted_q[$];
	stim_row_t plan[$];
	int fail_count;
	int rand_items;
	bit src_idle_on;
	bit sink_idle_on;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic sqr_pkg::result_t beat_res(logic [sqr_pkg::CHAR_W-1:0] c, logic e,
		logic [sqr_pkg::LEN_W-1:0] l);
		sqr_pkg::result_t r;
		r.char_val = c;
		r.is_end = e;
		r.len = l;
		return r;
	endfunction

	function automatic void add_row(logic [sqr_pkg::CHAR_W-1:0] c, logic last, int n,
		sqr_pkg::result_t r0 = '0, sqr_pkg::result_t r1 = '0, sqr_pkg::result_t r2 = '0);
		stim_row_t row;
		row.ch = c;
		row.last = last;
		row.typed_n = n;
		row.r0 = r0;
		row.r1 = r1;
		row.r2 = r2;
		plan.push_back(row);
	endfunction

	function automatic void emit_char(logic [sqr_pkg::CHAR_W-1:0] c);
		if (word_st.count != sqr_pkg::LEN_CAP)
			word_st.count = word_st.count + 1'b1;
		dequoted_q.push_back(beat_res(c, 1'b0, word_st.count));
	endfunction

	// Advances the word state by one source character and queues what it yields.
	function automatic void dequote_char(logic [sqr_pkg::CHAR_W-1:0] c, logic last);
		case (word_st.mode)
			sqr_pkg::MODE_SINGLE: begin
				if (c == sqr_pkg::CH_SQUOTE)
					word_st.mode = sqr_pkg::MODE_PLAIN;
				else
					emit_char(c);
			end
			sqr_pkg::MODE_DOUBLE: begin
				if (word_st.esc) begin
					word_st.esc = 1'b0;
					if (c != sqr_pkg::CH_DQUOTE && c != sqr_pkg::CH_SQUOTE &&
						c != sqr_pkg::CH_DOLLAR && c != sqr_pkg::CH_NEWLINE)
						emit_char(sqr_pkg::CH_BACKSLASH);
					emit_char(c);
				end else if (c == sqr_pkg::CH_BACKSLASH) begin
					word_st.esc = 1'b1;
				end else if (c == sqr_pkg::CH_DQUOTE) begin
					word_st.mode = sqr_pkg::MODE_PLAIN;
				end else begin
					emit_char(c);
				end
			end
			default: begin
				word_st.mode = sqr_pkg::MODE_PLAIN;
				if (word_st.esc) begin
					word_st.esc = 1'b0;
					emit_char(c);
				end else if (c == sqr_pkg::CH_BACKSLASH) begin
					word_st.esc = 1'b1;
				end else if (c == sqr_pkg::CH_SQUOTE) begin
					word_st.mode = sqr_pkg::MODE_SINGLE;
				end else if (c == sqr_pkg::CH_DQUOTE) begin
					word_st.mode = sqr_pkg::MODE_DOUBLE;
				end else begin
					emit_char(c);
				end
			end
		endcase
		if (last) begin
			dequoted_q.push_back(beat_res('0, 1'b1, word_st.count));
			word_st.mode = sqr_pkg::MODE_PLAIN;
			word_st.esc = 1'b0;
			word_st.count = '0;
		end
	endfunction

	task automatic send_char(stim_row_t row);
		int gap;
		int n0;
		gap = src_idle_on ? $urandom_range(0, 10) : 0;
		if (gap > 0) begin
			chars_if.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		chars_if.valid = 1'b1;
		chars_if.char_in = row.ch;
		chars_if.last_char = row.last;
		do @(posedge clk); while (!chars_if.ready);
		n0 = dequoted_q.size();
		dequote_char(row.ch, row.last);
		if (row.typed_n >= 0) begin
			while (dequoted_q.size() > n0)
				void'(dequoted_q.pop_back());
			if (row.typed_n > 0) dequoted_q.push_back(row.r0);
			if (row.typed_n > 1) dequoted_q.push_back(row.r1);
			if (row.typed_n > 2) dequoted_q.push_back(row.r2);
		end
		@(negedge clk);
	endtask

	function automatic logic [sqr_pkg::CHAR_W-1:0] pick_char();
		case ($urandom_range(0, 9))
			0, 1: return sqr_pkg::CH_BACKSLASH;
			2: return sqr_pkg::CH_SQUOTE;
			3: return sqr_pkg::CH_DQUOTE;
			4: return sqr_pkg::CH_DOLLAR;
			5: return sqr_pkg::CH_NEWLINE;
			9: return sqr_pkg::CHAR_W'($urandom);
			default: return sqr_pkg::CHAR_W'($urandom_range(32, 126));
		endcase
	endfunction

	always @(posedge clk) begin : check_beat
		sqr_pkg::result_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (dequoted_q.size() == 0) begin
				$error("result beat with no expectation: char_out=%h is_end=%b out_length=%0d",
					res_if.char_out, res_if.is_end, res_if.out_length);
				fail_count++;
			end else begin
				want = dequoted_q.pop_front();
				if (res_if.char_out !== want.char_val) begin
					$error("char_out: expected %h, got %h", want.char_val, res_if.char_out);
					fail_count++;
				end
				if (res_if.is_end !== want.is_end) begin
					$error("is_end: expected %b, got %b", want.is_end, res_if.is_end);
					fail_count++;
				end
				if (res_if.out_length !== want.len) begin
					$error("out_length: expected %0d, got %0d", want.len, res_if.out_length);
					fail_count++;
				end
			end
		end
	end

	initial begin : result_sink
		int gap;
		res_if.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			gap = sink_idle_on ? $urandom_range(0, 10) : 0;
			if (gap > 0) begin
				res_if.ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			res_if.ready = 1'b1;
			do @(posedge clk); while (!res_if.valid);
			@(negedge clk);
		end
	end

	initial begin
		#2_000_000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin : stimulus
		int len;
		stim_row_t row;
		clk = 1'b0;
		arst_n = 1'b0;
		chars_if.valid = 1'b0;
		chars_if.char_in = '0;
		chars_if.last_char = 1'b0;
		fail_count = 0;
		rand_items = 0;
		src_idle_on = 1'b1;
		sink_idle_on = 1'b1;
		word_st.mode = sqr_pkg::MODE_PLAIN;
		word_st.esc = 1'b0;
		word_st.count = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		add_row(21'h000061, 1'b0, 1, beat_res(21'h000061, 1'b0, 16'd1));
		add_row(21'h000000, 1'b0, 1, beat_res(21'h000000, 1'b0, 16'd2));
		add_row(21'h1FFFFF, 1'b1, 2, beat_res(21'h1FFFFF, 1'b0, 16'd3),
			beat_res('0, 1'b1, 16'd3));
		add_row(21'h10FFFF, 1'b1, 2, beat_res(21'h10FFFF, 1'b0, 16'd1),
			beat_res('0, 1'b1, 16'd1));
		add_row(sqr_pkg::CH_BACKSLASH, 1'b1, 1, beat_res('0, 1'b1, 16'd0));
		add_row(sqr_pkg::CH_SQUOTE, 1'b0, -1);
		add_row(sqr_pkg::CH_DQUOTE, 1'b0, -1);
		add_row(sqr_pkg::CH_BACKSLASH, 1'b0, -1);
		add_row(sqr_pkg::CH_SQUOTE, 1'b0, -1);
		add_row(sqr_pkg::CH_DQUOTE, 1'b0, -1);
		add_row(sqr_pkg::CH_BACKSLASH, 1'b0, -1);
		add_row(sqr_pkg::CH_DOLLAR, 1'b0, -1);
		add_row(sqr_pkg::CH_BACKSLASH, 1'b0, -1);
		add_row(sqr_pkg::CH_SQUOTE, 1'b0, -1);
		add_row(sqr_pkg::CH_BACKSLASH, 1'b0, -1);
		add_row(sqr_pkg::CH_NEWLINE, 1'b0, -1);
		add_row(sqr_pkg::CH_BACKSLASH, 1'b0, -1);
		add_row(sqr_pkg::CH_DQUOTE, 1'b0, -1);
		add_row(sqr_pkg::CH_BACKSLASH, 1'b0, -1);
		add_row(sqr_pkg::CH_BACKSLASH, 1'b0, -1);
		add_row(sqr_pkg::CH_DQUOTE, 1'b0, -1);
		add_row(sqr_pkg::CH_BACKSLASH, 1'b0, -1);
		add_row(sqr_pkg::CH_DQUOTE, 1'b0, -1);
		add_row(sqr_pkg::CH_SQUOTE, 1'b1, -1);
		add_row(sqr_pkg::CH_DQUOTE, 1'b0, -1);
		add_row(sqr_pkg::CH_BACKSLASH, 1'b0, -1);
		add_row(21'h00007A, 1'b1, -1);
		foreach (plan[i])
			send_char(plan[i]);

		row.typed_n = -1;
		while (rand_items < 150) begin
			src_idle_on = ($urandom_range(0, 3) != 0);
			sink_idle_on = ($urandom_range(0, 3) != 0);
			len = $urandom_range(1, 12);
			for (int i = 0; i < len; i++) begin
				row.ch = pick_char();
				row.last = (i == len - 1);
				send_char(row);
				rand_items++;
			end
		end
		chars_if.valid = 1'b0;

		while (dequoted_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
